### design/double_to_int32_rounding_convert_unit_assert.svh
// assertion macros
`ifndef DOUBLE_TO_INT32_ROUNDING_CONVERT_UNIT_ASSERT_SVH
`define DOUBLE_TO_INT32_ROUNDING_CONVERT_UNIT_ASSERT_SVH
`ifndef SYNTH
`define CHK_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CHK_IMPL(label, ante, cons)
`define CHK_NEXT(label, ante, cons)
`endif
`endif

### design/d2i_pkg.sv
package d2i_pkg;
    typedef enum logic [1:0] {
        RM_ZERO = 2'd0,
        RM_NEAR = 2'd1,
        RM_POS  = 2'd2,
        RM_NEG  = 2'd3
    } round_mode_t;

    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  round_mode;
        logic [63:0] double_bits;
    } in_item_t;

    typedef struct packed {
        logic [31:0] int_result;
        logic        range_error;
    } out_item_t;
endpackage

### design/double_to_int32_rounding_convert_unit.sv
// channel  | valid     | stall     | payload
// in       | in_valid  | in_stall  | in_data  (in_item_t)
// out      | out_valid | out_stall | out_data (out_item_t)
// One transaction per cycle while out_stall does not hold the pipeline; an accepted item
// passes the input register, then the result register, from which it is offered.
// rst_n clears the valid bits only.
// out_stall holds both stages; in_stall is high only while both are full and stalled.
`include "double_to_int32_rounding_convert_unit_assert.svh"
module double_to_int32_rounding_convert_unit
    import d2i_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);
    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_reg;
    logic      s2_valid_reg, s2_valid_next;
    out_item_t s2_reg, s2_next;
    logic      adv2, adv1;

    assign adv2     = !s2_valid_reg || !out_stall;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_stall = !adv1;
    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

    always_comb
    begin
        s1_valid_next = adv1 ? in_valid : s1_valid_reg;
        s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;
    end

    // conversion
    logic        neg, is_nan, huge;
    logic [10:0] expo;
    logic [52:0] mant;
    logic [11:0] shift;
    logic [5:0]  sh;
    logic [32:0] ip;
    logic [52:0] rem, half;
    logic        inc;
    logic [33:0] mag;
    round_mode_t rm;

    always_comb
    begin
        neg    = s1_reg.double_bits[63];
        expo   = s1_reg.double_bits[62:52];
        rm     = round_mode_t'(s1_reg.round_mode);
        is_nan = (expo == 11'h7FF) && (s1_reg.double_bits[51:0] != '0);
        huge   = (expo >= 11'd1056);
        mant   = {(expo != '0), s1_reg.double_bits[51:0]};
        shift  = (expo == '0) ? 12'd1074 : (12'd1075 - {1'b0, expo});
        sh     = shift[5:0];
        ip     = '0;
        rem    = mant;
        half   = '0;
        if (shift < 12'd53)
        begin
            ip   = 33'(mant >> sh);
            rem  = mant & ((53'd1 << sh) - 53'd1);
            half = 53'd1 << (sh - 6'd1);
        end
        case (rm)
            RM_ZERO: inc = 1'b0;
            RM_NEAR: inc = (shift < 12'd54) && (shift < 12'd53 ?
                           ((rem > half) || ((rem == half) && ip[0])) :
                           (mant > {1'b1, 52'd0}));
            RM_POS:  inc = (rem != '0) && !neg;
            default: inc = (rem != '0) && neg;
        endcase
        // shift == 53: the half point is bit 52 of mant, ip is zero so ties go down
        mag = huge ? {1'b1, 33'd0} : ({1'b0, ip} + 34'(inc));
        s2_next.range_error = 1'b0;
        s2_next.int_result  = mag[31:0];
        if (is_nan)
        begin
            s2_next.int_result  = '0;
            s2_next.range_error = 1'b1;
        end
        else if (s1_reg.opcode == OP_UNSIGNED)
        begin
            if (neg && mag != '0)
            begin
                s2_next.int_result  = '0;
                s2_next.range_error = 1'b1;
            end
            else if (mag[33:32] != '0)
            begin
                s2_next.int_result  = '1;
                s2_next.range_error = 1'b1;
            end
        end
        else if (neg)
        begin
            if (mag > 34'h080000000)
            begin
                s2_next.int_result  = 32'h80000000;
                s2_next.range_error = 1'b1;
            end
            else
                s2_next.int_result = 32'd0 - mag[31:0];
        end
        else if (mag > 34'h07FFFFFFF)
        begin
            s2_next.int_result  = 32'h7FFFFFFF;
            s2_next.range_error = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
            s1_reg <= in_data;
        if (adv2)
            s2_reg <= s2_next;
    end

    `CHK_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data))
    `CHK_IMPL(a_stall, in_stall, s1_valid_reg && s2_valid_reg && out_stall)
    `CHK_NEXT(a_fill, in_valid && !in_stall, s1_valid_reg)
    `CHK_IMPL(a_sat, out_valid && out_data.range_error,
              out_data.int_result == 32'h0 || out_data.int_result == 32'hFFFFFFFF || out_data.int_result == 32'h80000000 || out_data.int_result == 32'h7FFFFFFF)
endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import d2i_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    localparam int WATCHDOG_LIMIT = 2000;

    in_item_t  pending_items[$];
    out_item_t expected_results[$];
    int        sender_idle_pct = 17;
    int        receiver_idle_pct = 74;
    int        mismatches = 0;
    int        accepted_count = 0;
    int        checked_count = 0;
    int        idle_cycles = 0;
    bit        stimulus_done = 1'b0;

    double_to_int32_rounding_convert_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    function automatic out_item_t convert_double(in_item_t item);
        logic [10:0] expo;
        logic [51:0] frac;
        logic [52:0] mant;
        logic [63:0] ip;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] mag;
        int unsigned shift;
        bit          neg;
        bit          inc;
        bit          is_nan;
        out_item_t   res;
        expo = item.double_bits[62:52];
        frac = item.double_bits[51:0];
        neg = item.double_bits[63];
        is_nan = 1'b0;
        inc = 1'b0;
        if (expo == 11'h7FF) begin
            is_nan = (frac != 0);
            mag = 64'h0000_0100_0000_0000;
        end
        else if (expo >= 11'd1056) begin
            mag = 64'h0000_0100_0000_0000;
        end
        else begin
            if (expo == 0) begin
                mant = {1'b0, frac};
                shift = 1074;
            end
            else begin
                mant = {1'b1, frac};
                shift = 1075 - expo;
            end
            if (shift >= 64) begin
                ip = 0;
                rem = 64'(mant);
                half = 64'h8000_0000_0000_0000;
            end
            else begin
                ip = 64'(mant) >> shift;
                rem = 64'(mant) & ((64'd1 << shift) - 64'd1);
                half = 64'd1 << (shift - 1);
            end
            case (round_mode_t'(item.round_mode))
                RM_ZERO: inc = 1'b0;
                RM_NEAR: inc = (rem > half) || (rem == half && ip[0]);
                RM_POS:  inc = (rem != 0) && !neg;
                default: inc = (rem != 0) && neg;
            endcase
            mag = ip + 64'(inc);
        end
        res.range_error = 1'b0;
        if (is_nan) begin
            res.int_result = 32'd0;
            res.range_error = 1'b1;
        end
        else if (item.opcode == OP_UNSIGNED) begin
            if (neg && mag != 0) begin
                res.int_result = 32'd0;
                res.range_error = 1'b1;
            end
            else if (mag > 64'hFFFF_FFFF) begin
                res.int_result = 32'hFFFF_FFFF;
                res.range_error = 1'b1;
            end
            else begin
                res.int_result = mag[31:0];
            end
        end
        else if (neg) begin
            if (mag > 64'h8000_0000) begin
                res.int_result = 32'h8000_0000;
                res.range_error = 1'b1;
            end
            else begin
                res.int_result = 32'd0 - mag[31:0];
            end
        end
        else if (mag > 64'h7FFF_FFFF) begin
            res.int_result = 32'h7FFF_FFFF;
            res.range_error = 1'b1;
        end
        else begin
            res.int_result = mag[31:0];
        end
        return res;
    endfunction

    function automatic in_item_t make_item(logic op, logic [1:0] rm, logic [63:0] bits);
        in_item_t item;
        item.opcode = op;
        item.round_mode = rm;
        item.double_bits = bits;
        return item;
    endfunction

    function automatic logic [63:0] random_double();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: bits[62:52] = 11'(1023 + $urandom_range(0, 33));
            4: bits[62:52] = 11'(1053 + $urandom_range(0, 3));
            5: bits[62:52] = 11'(1000 + $urandom_range(0, 23));
            6:
            begin
                bits[62:52] = 11'(1023 + $urandom_range(0, 32));
                bits[31:0] = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h0;
            end
            7: bits[62:52] = ($urandom_range(0, 1) != 0) ? 11'h7FF : 11'h0;
            default: ;
        endcase
        return bits;
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (!in_valid || !in_stall) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= pending_items.pop_front();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(convert_double(in_data));
                accepted_count++;
            end
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: result %h err %b",
                                 out_data.int_result, out_data.range_error);
                end
                else begin
                    out_item_t exp_res;
                    exp_res = expected_results.pop_front();
                    checked_count++;
                    if (exp_res.int_result !== out_data.int_result
                        || exp_res.range_error !== out_data.range_error) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h err %b, got %h err %b",
                                     exp_res.int_result, exp_res.range_error,
                                     out_data.int_result, out_data.range_error);
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] directed[$];
        int n;
        directed = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                     64'h7FF8_0000_0000_0001, 64'h7FF0_0000_0000_0000,
                     64'hFFF0_0000_0000_0000, 64'h0000_0000_0000_0001,
                     64'h41EF_FFFF_FFE0_0000, 64'h41EF_FFFF_FFF0_0000,
                     64'h41DF_FFFF_FFE0_0000, 64'h41DF_FFFF_FFC0_0000,
                     64'hC1E0_0000_0000_0000, 64'hC1E0_0000_0010_0000,
                     64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000,
                     64'h3FF8_0000_0000_0000, 64'hBFF8_0000_0000_0000,
                     64'h4004_0000_0000_0000, 64'hC3F0_0000_0000_0000,
                     64'h7FEF_FFFF_FFFF_FFFF, 64'hBFD0_0000_0000_0000,
                     64'h41EF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
        n = 0;
        foreach (directed[i])
        begin
            pending_items.push_back(make_item(n[0], n[2:1], directed[i]));
            pending_items.push_back(make_item(~n[0], ~n[2:1], directed[i]));
            n++;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 1000; i++)
            pending_items.push_back(make_item(1'($urandom_range(0, 1)),
                                              2'($urandom_range(0, 3)),
                                              random_double()));
        wait (pending_items.size() < 660);
        sender_idle_pct = 74;
        receiver_idle_pct = 17;
        wait (pending_items.size() < 330);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (in_valid && in_stall)
            @(posedge clk);
        @(posedge clk);
        wait (expected_results.size() == 0);
        repeat (10) @(posedge clk);
        $display("converted %0d doubles over all rounding modes and both targets, %0d checked",
                 accepted_count, checked_count);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
